// ===== src/kct_pkg.sv =====
// Package for the keyed counter table: transaction payload types, operation and
// status codes, per-cell command struct and controller states. No dependencies.
package kct_pkg;

  localparam int unsigned KCT_ENTRIES = 16;
  localparam int unsigned KCT_KEY_W   = 31;
  localparam int unsigned KCT_CNT_W   = 31;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_GET = 2'd1;
  localparam logic [1:0] FUNC_SET = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NEG  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] key;
    logic signed [31:0] count;
  } kct_in_t;

  typedef struct packed {
    logic [KCT_CNT_W-1:0] value;
    logic [1:0]           status;
  } kct_out_t;

  typedef struct packed {
    logic                 cmp;
    logic                 upd;
    logic                 insert;
    logic                 add;
    logic [KCT_KEY_W-1:0] key;
    logic [KCT_CNT_W-1:0] count;
  } kct_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } kct_state_t;

endpackage

// ===== src/keyed_counter_table_unit.sv =====
// Keyed counter table top level: request/result handshakes, controller and the
// chain of kct_cell slots. Depends on kct_pkg and kct_cell.
//
// Usage:
//   in_valid/in_ready/in_data carries one request (func, key, count) per
//   transaction; out_valid/out_ready/out_data returns exactly one result
//   (value, status) for each request, in order.
//   In the accept cycle every slot compares the key in parallel and
//   registers its match; in the update state (ST_UPD) the matching slot
//   updates its count on an add or set, or the first free slot in the chain
//   takes the key, and the result is loaded into the output register.
//   out_valid is registered and rises when the result is loaded; a new
//   request is accepted only after the current one leaves the update state.
//   Slots fill from the left of the chain, so the free slot is found by each
//   cell looking at its neighbour's valid bit; the table is full when the last
//   slot is valid.
//   If the receiver stalls, the result waits in the output register and the
//   update cycle holds until the register can be reloaded.
//   Reset (rst_n low, synchronous) empties the table at once and drops any
//   pending result; no clearing pass is needed.
module keyed_counter_table_unit #(
  parameter int unsigned ENTRIES = kct_pkg::KCT_ENTRIES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kct_pkg::kct_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kct_pkg::kct_out_t out_data
);
  import kct_pkg::*;

  kct_state_t           state_r, state_nxt;
  kct_in_t              req_r;
  kct_out_t             out_r, out_nxt;
  logic                 out_valid_r;
  kct_cmd_t             cmd;
  logic [ENTRIES:0]     chain;
  logic [ENTRIES-1:0]   hits;
  logic [KCT_CNT_W-1:0] cell_count [ENTRIES];
  logic [KCT_CNT_W-1:0] found;
  logic                 any_hit;
  logic                 full;
  logic                 neg;
  logic                 known;
  logic                 upd_go;
  logic                 accept;

  assign chain[0] = 1'b1;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kct_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (chain[i]),
      .valid      (chain[i+1]),
      .hit        (hits[i]),
      .count      (cell_count[i])
    );
  end

  always_comb begin
    found = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      found = found | (hits[i] ? cell_count[i] : '0);
    end
  end

  assign any_hit  = |hits;
  assign full     = chain[ENTRIES];
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign upd_go   = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign neg      = req_r.key[31] || ((req_r.func == FUNC_SET) && req_r.count[31]);
  assign known    = (req_r.func == FUNC_ADD) || (req_r.func == FUNC_GET) ||
                    (req_r.func == FUNC_SET);

  always_comb begin
    cmd.cmp    = accept;
    cmd.upd    = upd_go && !neg &&
                 ((req_r.func == FUNC_ADD) || (req_r.func == FUNC_SET));
    cmd.insert = !any_hit;
    cmd.add    = (req_r.func == FUNC_ADD);
    cmd.key    = (state_r == ST_IDLE) ? in_data.key[KCT_KEY_W-1:0]
                                      : req_r.key[KCT_KEY_W-1:0];
    cmd.count  = req_r.count[KCT_CNT_W-1:0];
  end

  always_comb begin
    out_nxt.value  = '0;
    out_nxt.status = STATUS_OK;
    if (known) begin
      if (neg) begin
        out_nxt.status = STATUS_NEG;
      end else begin
        case (req_r.func)
          FUNC_GET: begin
            out_nxt.value = found;
          end
          FUNC_ADD: begin
            if (any_hit) begin
              out_nxt.value = (&found) ? found : found + KCT_CNT_W'(1);
            end else if (full) begin
              out_nxt.status = STATUS_FULL;
            end else begin
              out_nxt.value = KCT_CNT_W'(1);
            end
          end
          default: begin
            if (!any_hit && full) begin
              out_nxt.status = STATUS_FULL;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (upd_go) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/kct_cell.sv =====
// One slot of the keyed counter table: key, count and valid bit, with its own
// comparator. Depends on kct_pkg; takes the valid bit of its left neighbour.
module kct_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kct_pkg::kct_cmd_t         cmd,
  input  logic                      prev_valid,
  output logic                      valid,
  output logic                      hit,
  output logic [kct_pkg::KCT_CNT_W-1:0] count
);
  import kct_pkg::*;

  logic                 valid_r;
  logic                 hit_r;
  logic [KCT_KEY_W-1:0] key_r;
  logic [KCT_CNT_W-1:0] count_r;
  logic                 take;
  logic [KCT_CNT_W-1:0] inc_count;

  assign take      = cmd.upd && cmd.insert && !valid_r && prev_valid;
  assign inc_count = (&count_r) ? count_r : count_r + KCT_CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      if (cmd.cmp) begin
        hit_r <= valid_r && (key_r == cmd.key);
      end
      if (take) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r   <= cmd.key;
      count_r <= cmd.add ? KCT_CNT_W'(1) : cmd.count;
    end else if (cmd.upd && hit_r) begin
      count_r <= cmd.add ? inc_count : cmd.count;
    end
  end

  assign valid = valid_r;
  assign hit   = hit_r;
  assign count = count_r;

endmodule

// ===== verif/kct_result_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for keyed_counter_table_unit: watches both transaction channels,
// keeps its own copy of the key table and compares every result. Depends on kct_pkg.
module kct_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  kct_pkg::kct_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  kct_pkg::kct_out_t out_data,
  output int                mismatches,
  output int                outstanding
);
  import kct_pkg::*;

  localparam logic [KCT_CNT_W-1:0] COUNT_CEIL = '1;

  logic [KCT_KEY_W-1:0] slot_key   [KCT_ENTRIES];
  logic [KCT_CNT_W-1:0] slot_count [KCT_ENTRIES];
  logic                 slot_used  [KCT_ENTRIES];
  kct_out_t             expected_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  end

  task automatic flag(string msg);
    if (mismatches < 40) begin
      $display("%0t ns: mismatch, %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic kct_out_t tally(kct_in_t req);
    kct_out_t             res;
    int                   hit;
    int                   spare;
    logic [KCT_KEY_W-1:0] k;
    res.value  = '0;
    res.status = STATUS_OK;
    hit        = -1;
    spare      = -1;
    k          = req.key[KCT_KEY_W-1:0];
    if (req.func == FUNC_ADD || req.func == FUNC_GET || req.func == FUNC_SET) begin
      if (req.key < 0 || (req.func == FUNC_SET && req.count < 0)) begin
        res.status = STATUS_NEG;
      end else begin
        for (int i = KCT_ENTRIES - 1; i >= 0; i--) begin
          if (slot_used[i] && slot_key[i] == k) hit = i;
          if (!slot_used[i]) spare = i;
        end
        if (req.func == FUNC_GET) begin
          if (hit >= 0) res.value = slot_count[hit];
        end else if (hit >= 0) begin
          if (req.func == FUNC_ADD) begin
            if (slot_count[hit] != COUNT_CEIL) slot_count[hit] = slot_count[hit] + 1'b1;
            res.value = slot_count[hit];
          end else begin
            slot_count[hit] = req.count[KCT_CNT_W-1:0];
          end
        end else if (spare < 0) begin
          res.status = STATUS_FULL;
        end else begin
          slot_used[spare] = 1'b1;
          slot_key[spare]  = k;
          if (req.func == FUNC_ADD) begin
            slot_count[spare] = KCT_CNT_W'(1);
            res.value         = KCT_CNT_W'(1);
          end else begin
            slot_count[spare] = req.count[KCT_CNT_W-1:0];
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    kct_out_t want;
    if (!rst_n) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag($sformatf("unexpected result value %0d status %0d",
                         out_data.value, out_data.status));
        end else begin
          want = expected_results.pop_front();
          if (out_data.value !== want.value) begin
            flag($sformatf("value %0d, want %0d", out_data.value, want.value));
          end
          if (out_data.status !== want.status) begin
            flag($sformatf("status %0d, want %0d", out_data.status, want.status));
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(tally(in_data));
      outstanding <= expected_results.size();
    end
  end

endmodule

// ===== verif/tb_keyed_counter_table_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for keyed_counter_table_unit: clock, reset, request stimulus and
// result-side back-pressure. Depends on kct_pkg, the block and kct_result_checker.
module tb_keyed_counter_table_unit;
  import kct_pkg::*;

  localparam logic [1:0]  FUNC_NONE    = 2'd3;
  localparam int unsigned KEY_POOL     = 22;
  localparam int unsigned RANDOM_ITEMS = 900;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  kct_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  kct_out_t    out_data;
  logic        calm      = 1'b0;
  int unsigned ready_hold = 0;
  int          mismatches;
  int          outstanding;

  logic [KCT_KEY_W-1:0] key_pool [KEY_POOL];

  keyed_counter_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  kct_result_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned pause_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned sender_gap();
    if (calm || $urandom_range(0, 9) < 6) return 0;
    return pause_len();
  endfunction

  function automatic kct_in_t make_req(logic [1:0] f, logic [31:0] k, logic [31:0] c);
    kct_in_t r;
    r.func  = f;
    r.key   = k;
    r.count = c;
    return r;
  endfunction

  function automatic kct_in_t random_request();
    int unsigned pick;
    logic [1:0]  f;
    logic [31:0] k;
    logic [31:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 40)      f = FUNC_ADD;
    else if (pick < 70) f = FUNC_GET;
    else if (pick < 95) f = FUNC_SET;
    else                f = FUNC_NONE;
    pick = $urandom_range(0, 99);
    if (pick < 75)      k = {1'b0, key_pool[$urandom_range(0, KEY_POOL - 1)]};
    else if (pick < 85) k = $urandom | 32'h8000_0000;
    else                k = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 15)      c = $urandom | 32'h8000_0000;
    else if (pick < 40) c = 32'h7FFF_FFFF - $urandom_range(0, 15);
    else if (pick < 60) c = $urandom_range(0, 20);
    else                c = $urandom & 32'h7FFF_FFFF;
    return make_req(f, k, c);
  endfunction

  task automatic send(kct_in_t req);
    int unsigned gap;
    gap = sender_gap();
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every issued request has its result back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      ready_hold <= pause_len() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 31'd5;
    key_pool[3] = 31'd7;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = KCT_KEY_W'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send(make_req(FUNC_ADD, 32'd5, 32'd0));
    send(make_req(FUNC_ADD, 32'd5, 32'hFFFF_FFFF));
    send(make_req(FUNC_GET, 32'd5, 32'd0));
    send(make_req(FUNC_GET, 32'd7, 32'h8000_0000));
    send(make_req(FUNC_SET, 32'd7, 32'h7FFF_FFFE));
    send(make_req(FUNC_ADD, 32'd7, 32'd0));
    send(make_req(FUNC_ADD, 32'd7, 32'd0));
    send(make_req(FUNC_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send(make_req(FUNC_ADD, 32'd0, 32'd0));
    send(make_req(FUNC_SET, 32'd5, 32'hFFFF_FFFF));
    send(make_req(FUNC_SET, 32'd5, 32'h8000_0000));
    send(make_req(FUNC_ADD, 32'h8000_0000, 32'd0));
    send(make_req(FUNC_GET, 32'hFFFF_FFFF, 32'd0));
    send(make_req(FUNC_SET, 32'hFFFF_FFFF, 32'd3));
    send(make_req(FUNC_NONE, 32'd5, 32'd9));
    send(make_req(FUNC_NONE, 32'h8000_0000, 32'hFFFF_FFFF));
    send(make_req(FUNC_SET, 32'd5, 32'd0));
    send(make_req(FUNC_GET, 32'd5, 32'd0));
    send(make_req(FUNC_GET, 32'h7FFF_FFFF, 32'd0));
    send(make_req(FUNC_GET, 32'd0, 32'd0));
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) calm <= ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) drain();
      send(random_request());
    end
    drain();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("keyed_counter_table_unit verification clean");
    end else begin
      $display("keyed_counter_table_unit verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("keyed_counter_table_unit verification failed");
    $finish;
  end

endmodule

// ===== keyed_counter_table_unit.f =====
src/kct_pkg.sv
src/kct_cell.sv
src/keyed_counter_table_unit.sv
verif/kct_result_checker.sv
verif/tb_keyed_counter_table_unit.sv
